@@ rtl/core/sm3_pkg.sv @@
// sm3 package: constants, types and round helper functions
// used by the message schedule, round datapath and top level
`timescale 1ns / 1ps
`default_nettype none
package sm3_pkg;

    localparam int WORD_W = 32;

    localparam logic [WORD_W-1:0] IV [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };
    localparam logic [WORD_W-1:0] TJ_LOW  = 32'h79CC4519;
    localparam logic [WORD_W-1:0] TJ_HIGH = 32'h7A879D8A;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int LEN_BITS_POS = 448;
    localparam logic [3:0] LEN_WORD_POS = 4'(LEN_BITS_POS / 32);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMPRESS,
        ST_PAD,
        ST_OUTPUT
    } sm3_state_t;

    // control from sequencer to round unit
    typedef struct packed {
        logic load;    // copy chain value into work registers
        logic round;   // run one round
        logic fold;    // xor work registers into chain value
        logic reinit;  // chain value back to iv
    } sm3_ctrl_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input logic [4:0] n);
        logic [2*WORD_W-1:0] d;
        d = {x, x} << n;
        return d[2*WORD_W-1:WORD_W];
    endfunction

    function automatic logic [WORD_W-1:0] perm0(input logic [WORD_W-1:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [WORD_W-1:0] perm1(input logic [WORD_W-1:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/sm3_sched.sv @@
// sm3 message schedule: 16-word sliding window, one expanded word per round
// depends on sm3_pkg
`timescale 1ns / 1ps
`default_nettype none
module sm3_sched (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [3:0]                wr_idx,
    input  wire logic [sm3_pkg::WORD_W-1:0] wr_data,
    input  wire logic                      shift_en,
    output logic [sm3_pkg::WORD_W-1:0]     w_j,
    output logic [sm3_pkg::WORD_W-1:0]     w_j4
);
    import sm3_pkg::*;

    logic [WORD_W-1:0] win_reg [16];
    logic [WORD_W-1:0] w_new;

    assign w_j  = win_reg[0];
    assign w_j4 = win_reg[4];

    // expansion of word j+16 from the window
    always_comb begin
        w_new = perm1(win_reg[0] ^ win_reg[7] ^ rotl(win_reg[13], 5'd15))
                ^ rotl(win_reg[3], 5'd7) ^ win_reg[10];
    end

    // fill during load, slide during rounds
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            win_reg[wr_idx] <= wr_data;
        end else if (shift_en) begin
            for (int k = 0; k < 15; k++) begin
                win_reg[k] <= win_reg[k+1];
            end
            win_reg[15] <= w_new;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/sm3_round.sv @@
// sm3 round unit: work registers a..h, one round per cycle while ctrl.round is set, chain value
// depends on sm3_pkg
`timescale 1ns / 1ps
`default_nettype none
module sm3_round (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire sm3_pkg::sm3_ctrl_t         ctrl,
    input  wire logic [5:0]                 round_idx,
    input  wire logic [sm3_pkg::WORD_W-1:0] w_j,
    input  wire logic [sm3_pkg::WORD_W-1:0] w_j4,
    input  wire logic [1:0]                 part_sel,
    output logic [63:0]                     part_data
);
    import sm3_pkg::*;

    logic [WORD_W-1:0] cv_reg [8];
    logic [WORD_W-1:0] wk_reg [8];
    logic [WORD_W-1:0] a12, ss1, ss2, ffv, ggv, tt1, tt2, tj;
    logic early;

    // one compression round
    always_comb begin
        early = (round_idx < 6'd16);
        tj    = early ? TJ_LOW : TJ_HIGH;
        a12   = rotl(wk_reg[0], 5'd12);
        ss1   = rotl(a12 + wk_reg[4] + rotl(tj, round_idx[4:0]), 5'd7);
        ss2   = ss1 ^ a12;
        ffv   = early ? (wk_reg[0] ^ wk_reg[1] ^ wk_reg[2])
                      : ((wk_reg[0] & wk_reg[1]) | (wk_reg[0] & wk_reg[2])
                         | (wk_reg[1] & wk_reg[2]));
        ggv   = early ? (wk_reg[4] ^ wk_reg[5] ^ wk_reg[6])
                      : ((wk_reg[4] & wk_reg[5]) | (~wk_reg[4] & wk_reg[6]));
        tt1   = ffv + wk_reg[3] + ss2 + (w_j ^ w_j4);
        tt2   = ggv + wk_reg[7] + ss1 + w_j;
    end

    // work registers
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            wk_reg <= cv_reg;
        end else if (ctrl.round) begin
            wk_reg[0] <= tt1;
            wk_reg[1] <= wk_reg[0];
            wk_reg[2] <= rotl(wk_reg[1], 5'd9);
            wk_reg[3] <= wk_reg[2];
            wk_reg[4] <= perm0(tt2);
            wk_reg[5] <= wk_reg[4];
            wk_reg[6] <= rotl(wk_reg[5], 5'd19);
            wk_reg[7] <= wk_reg[6];
        end
    end

    // chain value
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.reinit) begin
            cv_reg <= IV;
        end else if (ctrl.fold) begin
            for (int k = 0; k < 8; k++) begin
                cv_reg[k] <= cv_reg[k] ^ wk_reg[k];
            end
        end
    end

    assign part_data = {cv_reg[{part_sel, 1'b0}], cv_reg[{part_sel, 1'b1}]};

endmodule
`default_nettype wire

@@ rtl/core/sm3_hash_engine.sv @@
// sm3 hash engine top level: input buffering, padding sequencer, digest output
// depends on sm3_pkg, sm3_sched, sm3_round
//
// usage:
//   s_axis carries message words; tdata = msg_word (32 bits, first byte in
//   bits 31..24), tuser = word_bytes (3 bits), tlast = last_word.
//   m_axis carries four digest transactions per message; tdata = digest_part,
//   tuser = part_index, tlast = last_part.
// sequence:
//   each non-final word is taken while s_tready is high; the sixteenth word of a
//   block starts a compression of a load step, 64 rounds and a fold step
//   during which s_tready is low, so no new word is taken until the block
//   is folded into the chain value.
//   the rounds are counted by the sequencer and run on the single round unit.
//   a final word adds padding words at one per cycle, one or two
//   compressions, then the four digest parts.
// reset: chain value returns to the iv, counters clear, no output pending.
// stall: while m_tready is low the current part holds; no new input is
//   taken until all four parts are delivered.
`timescale 1ns / 1ps
`default_nettype none
module sm3_hash_engine (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // msg_word[31:0]
    input  wire logic [2:0]  s_tuser,   // word_bytes[2:0]
    input  wire logic        s_tlast,   // last_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // digest_part[63:0]
    output logic [1:0]       m_tuser,   // part_index[1:0]
    output logic             m_tlast    // last_part
);
    import sm3_pkg::*;

    sm3_state_t state_reg, state_next;
    logic [3:0]  pos_reg, pos_next;
    logic [63:0] len_reg, len_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [1:0]  part_reg, part_next;
    logic        fin_reg, fin_next;     // padding pending / in progress
    logic        extra_reg, extra_next; // a length block still needed
    logic        pend4_reg, pend4_next; // 0x80 word still to push
    logic        skip_reg, skip_next;   // current pad block takes no length words

    sm3_ctrl_t ctrl;
    logic wr_en;
    logic [31:0] wr_data;
    logic [31:0] w_j, w_j4;
    logic [2:0] nb;
    logic [31:0] keep;
    logic s_fire, m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;
    assign nb = (s_tuser > 3'd4) ? 3'd4 : s_tuser;

    // mask of kept bytes for a partial final word; the pad byte is or-ed in after it
    always_comb begin
        unique case (nb)
            3'd0:    keep = 32'h0;
            3'd1:    keep = 32'hFF000000;
            3'd2:    keep = 32'hFFFF0000;
            3'd3:    keep = 32'hFFFFFF00;
            default: keep = 32'hFFFFFFFF;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (pos_reg == 4'd15 || s_tlast)) begin
                    state_next = (pos_reg == 4'd15) ? ST_COMPRESS : ST_PAD;
                end
            end
            ST_COMPRESS: begin
                if (rnd_reg == 7'd65) begin
                    state_next = fin_reg ? (extra_reg ? ST_PAD : ST_OUTPUT) : ST_IDLE;
                end
            end
            ST_PAD: begin
                if (pos_reg == 4'd15) state_next = ST_COMPRESS;
            end
            ST_OUTPUT: begin
                if (m_fire && part_reg == 2'd3) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath control and counters
    always_comb begin
        ctrl        = '0;
        wr_en       = 1'b0;
        wr_data     = 32'h0;
        pos_next    = pos_reg;
        len_next    = len_reg;
        rnd_next    = rnd_reg;
        part_next   = part_reg;
        fin_next    = fin_reg;
        extra_next  = extra_reg;
        pend4_next  = pend4_reg;
        skip_next   = skip_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_fire) begin
                    wr_en    = 1'b1;
                    pos_next = pos_reg + 4'd1;
                    if (!s_tlast) begin
                        wr_data  = s_tdata;
                        len_next = len_reg + 64'd32;
                    end else begin
                        len_next   = len_reg + {58'd0, nb, 3'd0};
                        fin_next   = 1'b1;
                        extra_next = 1'b1;
                        pend4_next = (nb == 3'd4);
                        // pad byte in slot 14 leaves no room for the length
                        skip_next  = (nb == 3'd4) ? (pos_reg == LEN_WORD_POS - 4'd1)
                                                  : (pos_reg == LEN_WORD_POS);
                        if (nb == 3'd4) begin
                            wr_data = s_tdata;
                        end else begin
                            wr_data = (s_tdata & keep)
                                      | ({PAD_BYTE, 24'd0} >> {nb, 3'b000});
                        end
                    end
                end
            end
            ST_COMPRESS: begin
                rnd_next = rnd_reg + 7'd1;
                if (rnd_reg == 7'd0) begin
                    ctrl.load = 1'b1;
                end else if (rnd_reg == 7'd65) begin
                    ctrl.fold = 1'b1;
                    rnd_next  = 7'd0;
                end else begin
                    ctrl.round = 1'b1;
                end
            end
            ST_PAD: begin
                wr_en    = 1'b1;
                pos_next = pos_reg + 4'd1;
                if (pend4_reg) begin
                    wr_data    = {PAD_BYTE, 24'd0};
                    pend4_next = 1'b0;
                end else if (pos_reg == LEN_WORD_POS && extra_reg && !skip_reg) begin
                    wr_data = len_reg[63:32];
                end else if (pos_reg == 4'd15 && extra_reg && !skip_reg) begin
                    wr_data    = len_reg[31:0];
                    extra_next = 1'b0;
                end else begin
                    wr_data = 32'h0;
                end
                // the block after a zero-only block carries the length
                if (pos_reg == 4'd15) begin
                    skip_next = 1'b0;
                end
            end
            ST_OUTPUT: begin
                m_tvalid = 1'b1;
                if (m_fire) begin
                    part_next = part_reg + 2'd1;
                    if (part_reg == 2'd3) begin
                        ctrl.reinit = 1'b1;
                        fin_next    = 1'b0;
                        len_next    = 64'd0;
                        pos_next    = 4'd0;
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pos_reg    <= 4'd0;
            len_reg    <= 64'd0;
            rnd_reg    <= 7'd0;
            part_reg   <= 2'd0;
            fin_reg    <= 1'b0;
            extra_reg  <= 1'b0;
            pend4_reg  <= 1'b0;
            skip_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            rnd_reg    <= rnd_next;
            part_reg   <= part_next;
            fin_reg    <= fin_next;
            extra_reg  <= extra_next;
            pend4_reg  <= pend4_next;
            skip_reg   <= skip_next;
        end
    end

    sm3_sched u_sched (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_idx   (pos_reg),
        .wr_data  (wr_data),
        .shift_en (ctrl.round),
        .w_j      (w_j),
        .w_j4     (w_j4)
    );

    sm3_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .round_idx (6'(rnd_reg - 7'd1)),
        .w_j       (w_j),
        .w_j4      (w_j4),
        .part_sel  (part_reg),
        .part_data (m_tdata)
    );

    assign m_tuser = part_reg;
    assign m_tlast = (part_reg == 2'd3);

    // checks
    a_no_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output active together");
    a_rnd_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_COMPRESS) |-> (rnd_reg == 7'd0))
        else $error("round counter not cleared");
    a_out_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_tlast) |=> (state_reg == ST_IDLE && pos_reg == 4'd0))
        else $error("digest end did not return to idle");

endmodule
`default_nettype wire
